[src/itar_pkg.sv]
// Shared types, constants and helpers for the radix-to-ASCII converter.
`default_nettype none
package itar_pkg;

    localparam int VALUE_BITS_DEFAULT = 64;
    localparam int STORE_DEPTH        = 64;
    localparam int STORE_AW           = $clog2(STORE_DEPTH);
    localparam int CNT_W              = STORE_AW + 1;

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] DIGIT_TEN = 6'd10;
    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_A    = 7'h41;

    typedef struct packed {
        logic [63:0] value;
        logic [5:0]  radix;
    } in_req_t;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       last_digit;
        logic [6:0] text_length;
    } out_req_t;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic rd_init;
        logic rd_issue;
        logic out_load;
    } itar_cmd_t;

    typedef struct packed {
        logic div_last;
        logic quot_zero;
        logic store_full;
        logic rd_last;
        logic out_free;
    } itar_status_t;

    function automatic logic [5:0] sat_radix(input logic [5:0] r);
        logic [5:0] s;
        s = r;
        if (r < RADIX_MIN)
            s = RADIX_MIN;
        else if (r > RADIX_MAX)
            s = RADIX_MAX;
        return s;
    endfunction

    function automatic logic [6:0] ascii_of(input logic [5:0] d);
        logic [6:0] c;
        if (d < DIGIT_TEN)
            c = CHAR_ZERO + {1'b0, d};
        else
            c = CHAR_A + {1'b0, d - DIGIT_TEN};
        return c;
    endfunction

endpackage
`default_nettype wire

[src/itar_dpath.sv]
// Datapath: shift-subtract divider, digit store and output register.
`default_nettype none
module itar_dpath
    import itar_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire in_req_t      in_data,
    input  wire itar_cmd_t    cmd,
    output      itar_status_t status,
    output      logic         out_valid,
    input  wire logic         out_stall,
    output      out_req_t     out_data
);

    localparam int BIT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic [VALUE_BITS-1:0] quot_reg;
    logic [5:0]            rem_reg;
    logic [5:0]            radix_reg;
    logic [BIT_W-1:0]      bit_cnt_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [STORE_AW-1:0]   idx_reg;
    logic [5:0]            rd_data_reg;
    logic                  out_valid_reg;
    out_req_t              out_data_reg;
    logic [5:0]            mem [STORE_DEPTH];

    logic [6:0]            trial;
    logic                  fits;
    logic [5:0]            rem_next;
    logic [VALUE_BITS-1:0] quot_next;
    logic [CNT_W-1:0]      cnt_less_one;

    assign trial        = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign fits         = trial >= {1'b0, radix_reg};
    assign rem_next     = fits ? 6'(trial - {1'b0, radix_reg}) : trial[5:0];
    assign quot_next    = {quot_reg[VALUE_BITS-2:0], fits};
    assign cnt_less_one = cnt_reg - CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quot_reg  <= in_data.value[VALUE_BITS-1:0];
            radix_reg <= sat_radix(in_data.radix);
            rem_reg   <= '0;
        end
        else if (cmd.step)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
        else if (cmd.store)
        begin
            rem_reg <= '0;
        end

        if (cmd.store)
            mem[cnt_reg[STORE_AW-1:0]] <= rem_reg;

        if (cmd.rd_issue)
            rd_data_reg <= mem[idx_reg];

        if (cmd.out_load)
        begin
            out_data_reg.digit_char  <= ascii_of(rd_data_reg);
            out_data_reg.last_digit  <= (idx_reg == '0);
            out_data_reg.text_length <= 7'(cnt_reg) + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg   <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                bit_cnt_reg <= '0;
                cnt_reg     <= '0;
            end
            else if (cmd.step)
            begin
                bit_cnt_reg <= bit_cnt_reg + BIT_W'(1);
            end
            else if (cmd.store)
            begin
                bit_cnt_reg <= '0;
                cnt_reg     <= cnt_reg + CNT_W'(1);
            end

            if (cmd.rd_init)
                idx_reg <= cnt_less_one[STORE_AW-1:0];
            else if (cmd.out_load)
                idx_reg <= idx_reg - STORE_AW'(1);

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.div_last   = (bit_cnt_reg == BIT_W'(VALUE_BITS - 1));
    assign status.quot_zero  = (quot_reg == '0);
    assign status.store_full = (cnt_reg == CNT_W'(STORE_DEPTH));
    assign status.rd_last    = (idx_reg == '0);
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

[src/itar_ctrl.sv]
// Controller: sequences division, digit storage and reversed readout.
`default_nettype none
module itar_ctrl
    import itar_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output      logic         in_stall,
    input  wire itar_status_t status,
    output      itar_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_CHECK,
        ST_RD,
        ST_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.quot_zero || status.store_full)
                begin
                    cmd.rd_init = 1'b1;
                    state_next  = ST_RD;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = status.rd_last ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule
`default_nettype wire

[src/integer_to_ascii_radix.sv]
// Top level of the unsigned integer to ASCII digit converter.
// Takes one request holding an unsigned number (low VALUE_BITS bits used) and a
// radix, saturated into 2..36, and returns one request per digit, most
// significant first, with the last digit marked and the digit count plus one
// on every request. Zero gives the single digit '0'. One number is worked at a
// time: the shared restoring divider resolves one quotient bit per cycle for
// each digit, then the digit store is read back in reverse, each digit read
// and then loaded into the output register when it is free. A new number
// is taken once the last digit sits in the output register.
`default_nettype none
module integer_to_ascii_radix
    import itar_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output      logic     in_stall,
    input  wire in_req_t  in_data,
    output      logic     out_valid,
    input  wire logic     out_stall,
    output      out_req_t out_data
);

    itar_cmd_t    cmd;
    itar_status_t status;

    itar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    itar_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the unsigned integer to ASCII digit converter.
`default_nettype none
module tb_top
    import itar_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS = 64;
    localparam logic [63:0] VALUE_MASK =
        (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);
    localparam int RANDOM_NUMBERS = 400;
    localparam int IDLE_PERCENT = 18;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [63:0] value;
        logic [5:0]  radix;
        string       text;
    } number_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    in_req_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    out_req_t out_data;

    string       typed_digits = "";
    bit          calm = 1'b0;
    out_req_t    digits_due[$];
    int unsigned numbers_sent = 0;
    int unsigned digits_checked = 0;
    int unsigned mismatches = 0;

    integer_to_ascii_radix #(.VALUE_BITS(VALUE_BITS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Queue the digits of one number, most significant first.
    function automatic void queue_digits_of(input in_req_t req);
        logic [63:0] rest;
        logic [5:0]  base;
        logic [5:0]  remainders [STORE_DEPTH];
        int          count;
        int          k;
        out_req_t    digit;
        base = req.radix;
        if (base < RADIX_MIN)
            base = RADIX_MIN;
        else if (base > RADIX_MAX)
            base = RADIX_MAX;
        rest = req.value & VALUE_MASK;
        count = 0;
        do
        begin
            remainders[count] = 6'(rest % 64'(base));
            rest = rest / 64'(base);
            count++;
        end
        while (rest != 64'd0 && count < STORE_DEPTH);
        for (k = count - 1; k >= 0; k--)
        begin
            if (remainders[k] < DIGIT_TEN)
                digit.digit_char = CHAR_ZERO + 7'(remainders[k]);
            else
                digit.digit_char = CHAR_A + 7'(remainders[k] - DIGIT_TEN);
            digit.last_digit = (k == 0);
            digit.text_length = 7'(count + 1);
            digits_due.push_back(digit);
        end
    endfunction

    function automatic void queue_typed_digits(input string text);
        int       k;
        byte      ch;
        out_req_t digit;
        for (k = 0; k < text.len(); k++)
        begin
            ch = text[k];
            digit.digit_char = ch[6:0];
            digit.last_digit = (k == text.len() - 1);
            digit.text_length = 7'(text.len() + 1);
            digits_due.push_back(digit);
        end
    endfunction

    // Check delivered digits, record accepted numbers, drive the output stall.
    always @(posedge clk)
    begin
        out_req_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (digits_due.size() == 0)
                report_mismatch($sformatf("digit 0x%02h with nothing expected",
                                          out_data.digit_char));
            else
            begin
                want = digits_due.pop_front();
                if (out_data.digit_char !== want.digit_char)
                    report_mismatch($sformatf("digit_char 0x%02h, wanted 0x%02h",
                                              out_data.digit_char, want.digit_char));
                if (out_data.last_digit !== want.last_digit)
                    report_mismatch($sformatf("last_digit %b, wanted %b",
                                              out_data.last_digit, want.last_digit));
                if (out_data.text_length !== want.text_length)
                    report_mismatch($sformatf("text_length %0d, wanted %0d",
                                              out_data.text_length, want.text_length));
                digits_checked++;
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            if (typed_digits.len() != 0)
                queue_typed_digits(typed_digits);
            else
                queue_digits_of(in_data);
        end
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    task automatic send_number(input logic [63:0] value, input logic [5:0] radix,
                               input string text);
        in_req_t req;
        req.value = value;
        req.radix = radix;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        typed_digits <= text;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        numbers_sent++;
    endtask

    initial
    begin
        number_row_t plan[$];
        logic [63:0] value;
        logic [5:0]  radix;
        int          i;

        plan.push_back('{64'd0, 6'd10, "0"});
        plan.push_back('{64'd0, 6'd0, "0"});
        plan.push_back('{64'd0, 6'd63, "0"});
        plan.push_back('{64'd1, 6'd1, "1"});
        plan.push_back('{64'd2, 6'd0, "10"});
        plan.push_back('{64'd35, 6'd63, "Z"});
        plan.push_back('{64'd36, 6'd37, "10"});
        plan.push_back('{64'd36, 6'd36, "10"});
        plan.push_back('{64'd9, 6'd10, "9"});
        plan.push_back('{64'd10, 6'd11, "A"});
        plan.push_back('{64'd31, 6'd32, "V"});
        plan.push_back('{64'd255, 6'd16, "FF"});
        plan.push_back('{64'd1234567890, 6'd10, "1234567890"});
        plan.push_back('{64'h0123_4567_89AB_CDEF, 6'd16, "123456789ABCDEF"});
        plan.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 6'd16, "FFFFFFFFFFFFFFFF"});
        plan.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 6'd10, "18446744073709551615"});
        plan.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 6'd2, ""});
        plan.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 6'd36, ""});
        plan.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 6'd8, ""});
        plan.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 6'd35, ""});
        plan.push_back('{64'h8000_0000_0000_0000, 6'd2, ""});
        plan.push_back('{64'hAAAA_AAAA_AAAA_AAAA, 6'd2, ""});
        plan.push_back('{64'h5555_5555_5555_5555, 6'd3, ""});

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_number(plan[i].value, plan[i].radix, plan[i].text);

        // Hold off until every digit of the directed numbers is back.
        in_valid <= 1'b0;
        while (digits_due.size() != 0)
            @(posedge clk);

        for (i = 0; i < RANDOM_NUMBERS; i++)
        begin
            calm = (i >= 150 && i < 230);
            if ($urandom_range(0, 9) == 0)
                radix = 6'($urandom_range(0, 63));
            else
                radix = 6'($urandom_range(2, 36));
            case ($urandom_range(0, 9))
                0: value = 64'($urandom_range(0, 40));
                1: value = {$urandom(), $urandom()};
                default: value = {$urandom(), $urandom()} >> $urandom_range(0, 63);
            endcase
            send_number(value, radix, "");
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (digits_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Converted %0d numbers in bases 0..63 (saturated), %0d digits checked.",
                 numbers_sent, digits_checked);
        $display("Mismatches: %0d, digits still owed: %0d", mismatches, digits_due.size());
        if (mismatches == 0 && digits_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Timeout with %0d digits still owed", digits_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
